### rtl/core/pcrm_pkg.sv
// shared types and constants of the panel chain rectangle mapper
package pcrm_pkg;

  localparam int IN_W    = 16;
  localparam int COORD_W = 13;
  localparam int PH_W    = 9;
  localparam int PR_W    = 5;
  localparam int CHAIN_W = 15;
  localparam int OY_W    = 12;
  localparam int OR_W    = 3;
  localparam int MAX_PIECES = 16;
  localparam int DIV_STEPS  = COORD_W;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [2:0] REG_ROW_WIDTH   = 3'd0;
  localparam logic [2:0] REG_DISP_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PANEL_H     = 3'd2;
  localparam logic [2:0] REG_PANEL_ROWS  = 3'd3;
  localparam logic [2:0] REG_CHAIN_PIX   = 3'd4;
  localparam logic [2:0] REG_ORIENT      = 3'd5;
  localparam logic [2:0] REG_CHAIN_MODE  = 3'd6;

  localparam logic [COORD_W-1:0] RST_ROW_WIDTH   = 13'd64;
  localparam logic [COORD_W-1:0] RST_DISP_HEIGHT = 13'd32;
  localparam logic [PH_W-1:0]    RST_PANEL_H     = 9'd32;
  localparam logic [PR_W-1:0]    RST_PANEL_ROWS  = 5'd1;
  localparam logic [CHAIN_W-1:0] RST_CHAIN_PIX   = 15'd64;
  localparam logic [OR_W-1:0]    RST_ORIENT      = 3'd0;
  localparam logic [OR_W-1:0]    RST_CHAIN_MODE  = 3'd0;

  typedef struct packed {
    logic [COORD_W-1:0] row_width;
    logic [COORD_W-1:0] disp_height;
    logic [PH_W-1:0]    panel_h;
    logic [PR_W-1:0]    panel_rows;
    logic [CHAIN_W-1:0] chain_pix;
    logic [OR_W-1:0]    orient;
    logic [OR_W-1:0]    chain_mode;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic clip1;
    logic clip2;
    logic clip3;
    logic div_start;
    logic row_init;
    logic mul;
    logic emit_single;
    logic emit_piece;
  } cmd_t;

  typedef struct packed {
    logic drop1;
    logic drop2;
    logic chain_on;
    logic cfg_bad;
    logic div_done;
    logic row_out;
    logic slot_free;
    logic piece_last;
  } sts_t;

endpackage

### rtl/core/pcrm_rect_if.sv
// request channel carrying one fill rectangle
interface pcrm_rect_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcrm_pkg::IN_W-1:0]    rect_x;
  logic signed [pcrm_pkg::IN_W-1:0]    rect_y;
  logic signed [pcrm_pkg::IN_W-1:0]    rect_w;
  logic signed [pcrm_pkg::IN_W-1:0]    rect_h;

  modport source (output valid, output rect_x, output rect_y, output rect_w,
                  output rect_h, input ready);
  modport sink (input valid, input rect_x, input rect_y, input rect_w,
                input rect_h, output ready);
endinterface

### rtl/core/pcrm_piece_if.sv
// result channel carrying one physical rectangle piece
interface pcrm_piece_if;
  logic                              valid;
  logic                              ready;
  logic [pcrm_pkg::CHAIN_W-1:0]      out_x;
  logic [pcrm_pkg::OY_W-1:0]         out_y;
  logic [pcrm_pkg::COORD_W-1:0]      out_w;
  logic [pcrm_pkg::COORD_W-1:0]      out_h;
  logic                              last;

  modport source (output valid, output out_x, output out_y, output out_w,
                  output out_h, output last, input ready);
  modport sink (input valid, input out_x, input out_y, input out_w,
                input out_h, input last, output ready);
endinterface

### rtl/core/pcrm_cfg_regs.sv
// apb configuration register file
module pcrm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcrm_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcrm_pkg::DATA_W-1:0]   pwdata,
  output logic [pcrm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pcrm_pkg::cfg_t                cfg
);

  pcrm_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[pcrm_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        pcrm_pkg::REG_ROW_WIDTH:   cfg_nxt.row_width   = pwdata[pcrm_pkg::COORD_W-1:0];
        pcrm_pkg::REG_DISP_HEIGHT: cfg_nxt.disp_height = pwdata[pcrm_pkg::COORD_W-1:0];
        pcrm_pkg::REG_PANEL_H:     cfg_nxt.panel_h     = pwdata[pcrm_pkg::PH_W-1:0];
        pcrm_pkg::REG_PANEL_ROWS:  cfg_nxt.panel_rows  = pwdata[pcrm_pkg::PR_W-1:0];
        pcrm_pkg::REG_CHAIN_PIX:   cfg_nxt.chain_pix   = pwdata[pcrm_pkg::CHAIN_W-1:0];
        pcrm_pkg::REG_ORIENT:      cfg_nxt.orient      = pwdata[pcrm_pkg::OR_W-1:0];
        pcrm_pkg::REG_CHAIN_MODE:  cfg_nxt.chain_mode  = pwdata[pcrm_pkg::OR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pcrm_pkg::REG_ROW_WIDTH:   prdata = 32'(cfg_r.row_width);
      pcrm_pkg::REG_DISP_HEIGHT: prdata = 32'(cfg_r.disp_height);
      pcrm_pkg::REG_PANEL_H:     prdata = 32'(cfg_r.panel_h);
      pcrm_pkg::REG_PANEL_ROWS:  prdata = 32'(cfg_r.panel_rows);
      pcrm_pkg::REG_CHAIN_PIX:   prdata = 32'(cfg_r.chain_pix);
      pcrm_pkg::REG_ORIENT:      prdata = 32'(cfg_r.orient);
      pcrm_pkg::REG_CHAIN_MODE:  prdata = 32'(cfg_r.chain_mode);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_width   <= pcrm_pkg::RST_ROW_WIDTH;
      cfg_r.disp_height <= pcrm_pkg::RST_DISP_HEIGHT;
      cfg_r.panel_h     <= pcrm_pkg::RST_PANEL_H;
      cfg_r.panel_rows  <= pcrm_pkg::RST_PANEL_ROWS;
      cfg_r.chain_pix   <= pcrm_pkg::RST_CHAIN_PIX;
      cfg_r.orient      <= pcrm_pkg::RST_ORIENT;
      cfg_r.chain_mode  <= pcrm_pkg::RST_CHAIN_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/pcrm_divider.sv
// restoring divider, one quotient bit per cycle
module pcrm_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pcrm_pkg::COORD_W-1:0]  dividend,
  input  logic [pcrm_pkg::PH_W-1:0]     divisor,
  output logic                          busy,
  output logic [pcrm_pkg::COORD_W-1:0]  quotient,
  output logic [pcrm_pkg::PH_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(pcrm_pkg::DIV_STEPS + 1);

  logic                          busy_r, busy_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [pcrm_pkg::COORD_W-1:0]  quo_r, quo_nxt;
  logic [pcrm_pkg::PH_W-1:0]     rem_r, rem_nxt;
  logic [pcrm_pkg::PH_W:0]       shifted;
  logic [pcrm_pkg::PH_W+1:0]     trial;

  assign shifted = {rem_r, quo_r[pcrm_pkg::COORD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(pcrm_pkg::DIV_STEPS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[pcrm_pkg::PH_W+1]) begin
        rem_nxt = trial[pcrm_pkg::PH_W-1:0];
        quo_nxt = {quo_r[pcrm_pkg::COORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[pcrm_pkg::PH_W-1:0];
        quo_nxt = {quo_r[pcrm_pkg::COORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/core/pcrm_datapath.sv
// clipping, row split and piece placement datapath with output register
module pcrm_datapath #(
  parameter int MAX_PANEL_ROWS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcrm_pkg::cfg_t                       cfg,
  input  pcrm_pkg::cmd_t                       cmd,
  output pcrm_pkg::sts_t                       sts,
  input  logic signed [pcrm_pkg::IN_W-1:0]     rect_x,
  input  logic signed [pcrm_pkg::IN_W-1:0]     rect_y,
  input  logic signed [pcrm_pkg::IN_W-1:0]     rect_w,
  input  logic signed [pcrm_pkg::IN_W-1:0]     rect_h,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pcrm_pkg::CHAIN_W-1:0]         out_x,
  output logic [pcrm_pkg::OY_W-1:0]            out_y,
  output logic [pcrm_pkg::COORD_W-1:0]         out_w,
  output logic [pcrm_pkg::COORD_W-1:0]         out_h,
  output logic                                 out_last
);

  localparam int CW = pcrm_pkg::COORD_W;
  localparam int XW = pcrm_pkg::CHAIN_W;
  localparam int PW = pcrm_pkg::PH_W;
  localparam int RW = pcrm_pkg::PR_W;
  localparam int LIMIT_CAP = (MAX_PANEL_ROWS < pcrm_pkg::MAX_PIECES) ?
                             MAX_PANEL_ROWS : pcrm_pkg::MAX_PIECES;

  // captured request
  logic signed [pcrm_pkg::IN_W-1:0] ix_r, iy_r, iw_r, ih_r;
  // after origin clip and swap
  logic [XW-1:0] x1_r, y1_r, w1_r, h1_r;
  // after size clip
  logic [CW-1:0] x2_r, y2_r, w2_r, h2_r;
  // final virtual rectangle
  logic [CW-1:0] xf_r, yf_r, wf_r, hrem_r;
  // per piece
  logic [RW-1:0] row_r;
  logic          first_r;
  logic [XW-1:0] prod_r, off_r;
  // output register
  logic          ov_r;
  logic [XW-1:0] ox_r;
  logic [pcrm_pkg::OY_W-1:0] oy_r;
  logic [CW-1:0] ow_r, oh_r;
  logic          ol_r;

  logic signed [pcrm_pkg::IN_W:0] xs, ys, ws, hs, wa, ha;
  logic [XW-1:0] xa15, ya15, wa15, ha15;
  logic [XW:0]   sumx, sumy;
  logic [CW-1:0] w2c, h2c, x3, y3;
  logic [RW-1:0] limit, mrows, row_inc;
  logic [RW+CW-1:0] mfull;
  logic          odd, slot_free;
  logic [XW-1:0] off_c, cx, ox;
  logic [PW-1:0] avail, piece, cy;
  logic [CW-1:0] hnew;
  logic          div_busy;
  logic [CW-1:0] quo;
  logic [PW-1:0] rem;

  pcrm_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (yf_r),
    .divisor   (cfg.panel_h),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  // origin clip; the axis swap is applied when the result is registered
  always_comb begin
    xs = {ix_r[pcrm_pkg::IN_W-1], ix_r};
    ys = {iy_r[pcrm_pkg::IN_W-1], iy_r};
    ws = {iw_r[pcrm_pkg::IN_W-1], iw_r};
    hs = {ih_r[pcrm_pkg::IN_W-1], ih_r};
    wa = xs[pcrm_pkg::IN_W] ? ws + xs : ws;
    ha = ys[pcrm_pkg::IN_W] ? hs + ys : hs;
    xa15 = xs[pcrm_pkg::IN_W] ? '0 : xs[XW-1:0];
    ya15 = ys[pcrm_pkg::IN_W] ? '0 : ys[XW-1:0];
    wa15 = wa[XW-1:0];
    ha15 = ha[XW-1:0];
  end

  // size clip
  always_comb begin
    sumx = {1'b0, x1_r} + {1'b0, w1_r};
    sumy = {1'b0, y1_r} + {1'b0, h1_r};
    w2c  = (sumx >= (XW+1)'(cfg.row_width))   ? cfg.row_width - x1_r[CW-1:0] :
                                                 w1_r[CW-1:0];
    h2c  = (sumy >= (XW+1)'(cfg.disp_height)) ? cfg.disp_height - y1_r[CW-1:0] :
                                                 h1_r[CW-1:0];
  end

  assign x3 = cfg.orient[1] ? cfg.row_width - x2_r - w2_r : x2_r;
  assign y3 = cfg.orient[2] ? cfg.disp_height - y2_r - h2_r : y2_r;

  // row limit and per piece placement
  assign limit   = (cfg.panel_rows < RW'(LIMIT_CAP)) ? cfg.panel_rows : RW'(LIMIT_CAP);
  assign mrows   = cfg.panel_rows - row_r - 1'b1;
  assign mfull   = mrows * cfg.row_width;
  assign odd     = cfg.chain_mode[1] & row_r[0];
  assign off_c   = odd ? XW'(cfg.row_width) - XW'(xf_r) - XW'(wf_r) : XW'(xf_r);
  assign cx      = prod_r + off_r;
  assign ox      = cfg.chain_mode[2] ? cx : cfg.chain_pix - cx - XW'(wf_r);
  assign avail   = first_r ? cfg.panel_h - rem : cfg.panel_h;
  assign piece   = (hrem_r < CW'(avail)) ? hrem_r[PW-1:0] : avail;
  assign cy      = odd ? avail - piece : (first_r ? rem : '0);
  assign hnew    = hrem_r - CW'(piece);
  assign row_inc = row_r + 1'b1;

  assign slot_free = !ov_r || out_ready;

  always_comb begin
    sts.drop1      = wa[pcrm_pkg::IN_W] || (wa == '0) || ha[pcrm_pkg::IN_W] || (ha == '0);
    sts.drop2      = (x1_r >= XW'(cfg.row_width)) || (y1_r >= XW'(cfg.disp_height));
    sts.chain_on   = cfg.chain_mode[0];
    sts.cfg_bad    = (cfg.panel_h == '0) || (cfg.panel_rows == '0);
    sts.div_done   = !div_busy;
    sts.row_out    = quo >= CW'(limit);
    sts.slot_free  = slot_free;
    sts.piece_last = (hnew == '0) || (row_inc >= limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ix_r <= rect_x;
      iy_r <= rect_y;
      iw_r <= rect_w;
      ih_r <= rect_h;
    end
    if (cmd.clip1) begin
      if (cfg.orient[0]) begin
        x1_r <= ya15;
        y1_r <= xa15;
        w1_r <= ha15;
        h1_r <= wa15;
      end else begin
        x1_r <= xa15;
        y1_r <= ya15;
        w1_r <= wa15;
        h1_r <= ha15;
      end
    end
    if (cmd.clip2) begin
      x2_r <= x1_r[CW-1:0];
      y2_r <= y1_r[CW-1:0];
      w2_r <= w2c;
      h2_r <= h2c;
    end
    if (cmd.clip3) begin
      xf_r   <= x3;
      yf_r   <= y3;
      wf_r   <= w2_r;
      hrem_r <= h2_r;
    end
    if (cmd.row_init) begin
      row_r   <= quo[RW-1:0];
      first_r <= 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= mfull[XW-1:0];
      off_r  <= off_c;
    end
    if (cmd.emit_piece) begin
      row_r   <= row_inc;
      first_r <= 1'b0;
      hrem_r  <= hnew;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      ox_r <= XW'(xf_r);
      oy_r <= yf_r[pcrm_pkg::OY_W-1:0];
      ow_r <= wf_r;
      oh_r <= hrem_r;
      ol_r <= 1'b1;
    end else if (cmd.emit_piece) begin
      ox_r <= ox;
      oy_r <= pcrm_pkg::OY_W'(cy);
      ow_r <= wf_r;
      oh_r <= CW'(piece);
      ol_r <= sts.piece_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_piece) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_w     = ow_r;
  assign out_h     = oh_r;
  assign out_last  = ol_r;

endmodule

### rtl/core/pcrm_ctrl.sv
// sequencing state machine of the rectangle mapper
module pcrm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcrm_pkg::sts_t  sts,
  output pcrm_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLIP1  = 4'd1;
  localparam logic [3:0] S_CLIP2  = 4'd2;
  localparam logic [3:0] S_CLIP3  = 4'd3;
  localparam logic [3:0] S_SINGLE = 4'd4;
  localparam logic [3:0] S_DIVST  = 4'd5;
  localparam logic [3:0] S_DIVW   = 4'd6;
  localparam logic [3:0] S_ROWCHK = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CLIP1;
        end
      end
      S_CLIP1: begin
        cmd.clip1 = 1'b1;
        state_nxt = sts.drop1 ? S_IDLE : S_CLIP2;
      end
      S_CLIP2: begin
        cmd.clip2 = 1'b1;
        state_nxt = sts.drop2 ? S_IDLE : S_CLIP3;
      end
      S_CLIP3: begin
        cmd.clip3 = 1'b1;
        priority if (!sts.chain_on) begin
          state_nxt = S_SINGLE;
        end else if (sts.cfg_bad) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DIVST;
        end
      end
      S_SINGLE: begin
        if (sts.slot_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DIVST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = S_ROWCHK;
        end
      end
      S_ROWCHK: begin
        if (sts.row_out) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.row_init = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_piece = 1'b1;
          state_nxt      = sts.piece_last ? S_IDLE : S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/panel_chain_rect_mapper_unit.sv
// top level of the panel chain rectangle mapper
// Maps one fill rectangle request in virtual display coordinates onto the
// physical buffer of a panel chain, giving one piece per panel row touched
// (or a single piece without virtual chaining), the final piece marked by
// last. After its acceptance a request is clipped, then either the single
// piece is emitted, or the row lookup runs (the 13-step restoring divider
// of y by panel height is the dominant cost), followed per emitted piece by
// the row offset multiply and then the placement. A dropped rectangle is
// finished during clipping, or after the row lookup when it starts beyond
// the last panel row of the chain. A full output register holds the
// emitting state until the piece is taken. One request is in work at a
// time; the next one is taken while the last piece still waits in the
// output register. Registers are written through the APB port at byte
// address 4*index and must only be changed while no request is in work.
module panel_chain_rect_mapper_unit #(
  parameter int MAX_PANEL_ROWS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcrm_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcrm_pkg::DATA_W-1:0]   pwdata,
  output logic [pcrm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  pcrm_rect_if.sink                     in_rect,
  pcrm_piece_if.source                  out_piece
);

  pcrm_pkg::cfg_t cfg;
  pcrm_pkg::cmd_t cmd;
  pcrm_pkg::sts_t sts;

  pcrm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rect.valid),
    .in_ready (in_rect.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcrm_datapath #(
    .MAX_PANEL_ROWS (MAX_PANEL_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .rect_x    (in_rect.rect_x),
    .rect_y    (in_rect.rect_y),
    .rect_w    (in_rect.rect_w),
    .rect_h    (in_rect.rect_h),
    .out_valid (out_piece.valid),
    .out_ready (out_piece.ready),
    .out_x     (out_piece.out_x),
    .out_y     (out_piece.out_y),
    .out_w     (out_piece.out_w),
    .out_h     (out_piece.out_h),
    .out_last  (out_piece.last)
  );

endmodule

### bench/testbench.sv
// self-checking testbench for the panel chain rectangle mapper
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ROWS = 16;

  typedef struct {
    shortint x;
    shortint y;
    shortint w;
    shortint h;
  } rect_t;

  typedef struct {
    logic [pcrm_pkg::CHAIN_W-1:0] x;
    logic [pcrm_pkg::OY_W-1:0]    y;
    logic [pcrm_pkg::COORD_W-1:0] w;
    logic [pcrm_pkg::COORD_W-1:0] h;
    logic                         last;
  } piece_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [pcrm_pkg::ADDR_W-1:0] paddr;
  logic [pcrm_pkg::DATA_W-1:0] pwdata;
  logic [pcrm_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  pcrm_rect_if  in_rect ();
  pcrm_piece_if out_piece ();

  panel_chain_rect_mapper_unit #(.MAX_PANEL_ROWS(MAX_ROWS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_rect  (in_rect),
    .out_piece(out_piece)
  );

  pcrm_pkg::cfg_t layout;
  piece_t         pending_pieces[$];
  int             errors = 0;
  int             send_idle_pct = 29;
  int             recv_idle_pct = 29;
  int             hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  // expected pieces for one rectangle under the current layout
  function automatic void map_rect(input rect_t r);
    int x, y, w, h, t, wd, hd, ph, pr, limit, row, cx, cy, piece, ox;
    bit serp, topdown, first, odd;
    piece_t p;
    x = r.x;
    y = r.y;
    w = r.w;
    h = r.h;
    wd = int'(layout.row_width);
    hd = int'(layout.disp_height);
    ph = int'(layout.panel_h);
    pr = int'(layout.panel_rows);
    serp = layout.chain_mode[1];
    topdown = layout.chain_mode[2];
    first = 1'b1;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (w <= 0) return;
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (h <= 0) return;
    if (layout.orient[0]) begin
      t = x; x = y; y = t;
      t = w; w = h; h = t;
    end
    if (x >= wd || y >= hd) return;
    if (x + w >= wd) w = wd - x;
    if (y + h >= hd) h = hd - y;
    if (layout.orient[1]) x = wd - x - w;
    if (layout.orient[2]) y = hd - y - h;
    if (!layout.chain_mode[0]) begin
      p.x = x[pcrm_pkg::CHAIN_W-1:0];
      p.y = y[pcrm_pkg::OY_W-1:0];
      p.w = w[pcrm_pkg::COORD_W-1:0];
      p.h = h[pcrm_pkg::COORD_W-1:0];
      p.last = 1'b1;
      pending_pieces.push_back(p);
      return;
    end
    if (ph == 0 || pr == 0) return;
    limit = pr;
    if (limit > MAX_ROWS) limit = MAX_ROWS;
    if (limit > pcrm_pkg::MAX_PIECES) limit = pcrm_pkg::MAX_PIECES;
    row = y / ph;
    while (row < limit) begin
      odd = serp && row[0];
      if (odd) begin
        cx = (pr - row) * wd - x - w;
        if (first) begin
          cy = (row + 1) * ph - y;
          piece = (cy < h) ? cy : h;
          cy -= piece;
        end else begin
          piece = (ph < h) ? ph : h;
          cy = ph - piece;
        end
      end else begin
        cx = (pr - row - 1) * wd + x;
        if (first) begin
          cy = y - row * ph;
          piece = ph - cy;
          if (piece > h) piece = h;
        end else begin
          piece = (ph < h) ? ph : h;
          cy = 0;
        end
      end
      ox = topdown ? cx : int'(layout.chain_pix) - cx - w;
      h -= piece;
      p.x = ox[pcrm_pkg::CHAIN_W-1:0];
      p.y = cy[pcrm_pkg::OY_W-1:0];
      p.w = w[pcrm_pkg::COORD_W-1:0];
      p.h = piece[pcrm_pkg::COORD_W-1:0];
      p.last = (h <= 0) || (row + 1 >= limit);
      pending_pieces.push_back(p);
      if (h <= 0) break;
      row++;
      first = 1'b0;
    end
  endfunction

  // piece receiver and checker, with random and long stalls
  initial begin
    piece_t want;
    out_piece.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_piece.valid === 1'b1 && out_piece.ready === 1'b1) begin
        if (pending_pieces.size() == 0) begin
          $error("unexpected piece x=%0d y=%0d w=%0d h=%0d last=%0d", out_piece.out_x,
                 out_piece.out_y, out_piece.out_w, out_piece.out_h, out_piece.last);
          errors++;
        end else begin
          want = pending_pieces.pop_front();
          check_field("out_x", int'(want.x), int'(out_piece.out_x));
          check_field("out_y", int'(want.y), int'(out_piece.out_y));
          check_field("out_w", int'(want.w), int'(out_piece.out_w));
          check_field("out_h", int'(want.h), int'(out_piece.out_h));
          check_field("last", int'(want.last), int'(out_piece.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_piece.ready <= 1'b0;
      end else begin
        out_piece.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_rect(input rect_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_rect.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_rect.valid  <= 1'b1;
    in_rect.rect_x <= r.x;
    in_rect.rect_y <= r.y;
    in_rect.rect_w <= r.w;
    in_rect.rect_h <= r.h;
    @(posedge clk);
    while (in_rect.ready !== 1'b1) @(posedge clk);
    map_rect(r);
  endtask

  task automatic send_xywh(input int x, input int y, input int w, input int h);
    rect_t r;
    r.x = shortint'(x);
    r.y = shortint'(y);
    r.w = shortint'(w);
    r.h = shortint'(h);
    send_rect(r);
  endtask

  // all pieces back, then room for a request that yields none
  task automatic settle();
    in_rect.valid <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] idx, input bit wr,
                            input logic [pcrm_pkg::DATA_W-1:0] data,
                            output logic [pcrm_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [pcrm_pkg::DATA_W-1:0] reg_value(input pcrm_pkg::cfg_t c,
                                                           input logic [2:0] idx);
    case (idx)
      pcrm_pkg::REG_ROW_WIDTH:   return 32'(c.row_width);
      pcrm_pkg::REG_DISP_HEIGHT: return 32'(c.disp_height);
      pcrm_pkg::REG_PANEL_H:     return 32'(c.panel_h);
      pcrm_pkg::REG_PANEL_ROWS:  return 32'(c.panel_rows);
      pcrm_pkg::REG_CHAIN_PIX:   return 32'(c.chain_pix);
      pcrm_pkg::REG_ORIENT:      return 32'(c.orient);
      pcrm_pkg::REG_CHAIN_MODE:  return 32'(c.chain_mode);
      default:                   return '0;
    endcase
  endfunction

  task automatic verify_regs();
    logic [pcrm_pkg::DATA_W-1:0] rd;
    for (int i = pcrm_pkg::REG_ROW_WIDTH; i <= pcrm_pkg::REG_CHAIN_MODE; i++) begin
      apb_access(3'(i), 1'b0, '0, rd);
      check_field("prdata", int'(reg_value(layout, 3'(i))), int'(rd));
    end
  endtask

  task automatic apply_layout(input pcrm_pkg::cfg_t c);
    logic [pcrm_pkg::DATA_W-1:0] rd;
    settle();
    for (int i = pcrm_pkg::REG_ROW_WIDTH; i <= pcrm_pkg::REG_CHAIN_MODE; i++)
      apb_access(3'(i), 1'b1, reg_value(c, 3'(i)), rd);
    layout = c;
    verify_regs();
  endtask

  function automatic pcrm_pkg::cfg_t make_layout(input int wd, input int hd, input int ph,
                                                 input int pr, input int cp,
                                                 input int orient, input int mode);
    pcrm_pkg::cfg_t c;
    c.row_width   = wd[pcrm_pkg::COORD_W-1:0];
    c.disp_height = hd[pcrm_pkg::COORD_W-1:0];
    c.panel_h     = ph[pcrm_pkg::PH_W-1:0];
    c.panel_rows  = pr[pcrm_pkg::PR_W-1:0];
    c.chain_pix   = cp[pcrm_pkg::CHAIN_W-1:0];
    c.orient      = orient[pcrm_pkg::OR_W-1:0];
    c.chain_mode  = mode[pcrm_pkg::OR_W-1:0];
    return c;
  endfunction

  function automatic pcrm_pkg::cfg_t random_layout();
    int wd, hd, ph, pr, cp, pick;
    pick = $urandom_range(0, 9);
    wd = (pick == 0) ? 1 : (pick == 1) ? 4096 : $urandom_range(1, 256);
    pick = $urandom_range(0, 9);
    ph = (pick == 0) ? 1 : (pick == 1) ? 256 : $urandom_range(1, 48);
    pick = $urandom_range(0, 19);
    pr = (pick < 2) ? $urandom_range(17, 31) : (pick == 2) ? 0 : $urandom_range(1, 16);
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      hd = ph * pr;
      if (hd > 4096) hd = 4096;
      if (hd < 1) hd = 1;
    end else begin
      hd = (pick == 6) ? 4096 : (pick == 7) ? 1 : $urandom_range(1, 512);
    end
    pick = $urandom_range(0, 19);
    cp = (pick < 10) ? pr * wd : (pick < 13) ? 32767 : (pick < 15) ? 1 : $urandom_range(1, 32767);
    return make_layout(wd, hd, ph, pr, cp, $urandom_range(0, 7),
                       ($urandom_range(0, 9) < 8) ? ($urandom_range(0, 3) * 2 + 1)
                                                  : ($urandom_range(0, 3) * 2));
  endfunction

  function automatic rect_t random_rect();
    rect_t r;
    int span;
    span = (layout.row_width > layout.disp_height) ? int'(layout.row_width)
                                                   : int'(layout.disp_height);
    if ($urandom_range(0, 99) < 20) begin
      r.x = shortint'($urandom);
      r.y = shortint'($urandom);
      r.w = shortint'($urandom);
      r.h = shortint'($urandom);
    end else begin
      r.x = shortint'(int'($urandom_range(0, span + 8)) - 4);
      r.y = shortint'(int'($urandom_range(0, span + 8)) - 4);
      if ($urandom_range(0, 3) == 0) begin
        r.w = shortint'(int'($urandom_range(0, span + 16)) - 2);
        r.h = shortint'(int'($urandom_range(0, span + 16)) - 2);
      end else begin
        r.w = shortint'(int'($urandom_range(0, span / 2 + 8)) - 2);
        r.h = shortint'(int'($urandom_range(0, span / 2 + 8)) - 2);
      end
    end
    return r;
  endfunction

  task automatic test_default_layout();
    layout = make_layout(int'(pcrm_pkg::RST_ROW_WIDTH), int'(pcrm_pkg::RST_DISP_HEIGHT),
                         int'(pcrm_pkg::RST_PANEL_H), int'(pcrm_pkg::RST_PANEL_ROWS),
                         int'(pcrm_pkg::RST_CHAIN_PIX), int'(pcrm_pkg::RST_ORIENT),
                         int'(pcrm_pkg::RST_CHAIN_MODE));
    verify_regs();
    send_xywh(0, 0, 64, 32);
    send_xywh(10, 5, 8, 4);
    send_xywh(-5, -3, 10, 10);
    send_xywh(-32768, -32768, 32767, 32767);
    send_xywh(32767, 32767, 32767, 32767);
    send_xywh(0, 0, 0, 5);
    send_xywh(63, 31, -32768, 1);
  endtask

  task automatic test_chain_modes();
    int modes[4] = '{1, 3, 5, 7};
    foreach (modes[i]) begin
      apply_layout(make_layout(64, 128, 32, 4, 256, 0, modes[i]));
      send_xywh(0, 0, 64, 128);
      send_xywh(5, 40, 20, 70);
    end
  endtask

  task automatic test_special_layouts();
    // zero panel height, then zero panel rows, with chaining on
    apply_layout(make_layout(64, 128, 0, 4, 256, 0, 1));
    send_xywh(0, 0, 10, 10);
    apply_layout(make_layout(64, 128, 32, 0, 256, 0, 3));
    send_xywh(0, 0, 10, 10);
    // more panel rows than the chain supports
    apply_layout(make_layout(16, 4096, 8, 20, 320, 0, 1));
    send_xywh(0, 0, 16, 4096);
    // chain too short, x wraps
    apply_layout(make_layout(64, 64, 16, 4, 1, 0, 1));
    send_xywh(3, 3, 20, 50);
    apply_layout(make_layout(64, 48, 16, 3, 192, 3, 3));
    send_xywh(4, 2, 10, 30);
    apply_layout(make_layout(40, 96, 32, 3, 120, 6, 7));
    send_xywh(7, 9, 50, 12);
    apply_layout(make_layout(4096, 4096, 256, 16, 32767, 0, 7));
    send_xywh(0, 0, 32767, 32767);
    apply_layout(make_layout(1, 1, 1, 1, 1, 4, 1));
    send_xywh(0, 0, 1, 1);
  endtask

  task automatic test_random_traffic();
    repeat (15) begin
      apply_layout(random_layout());
      repeat (20) send_rect(random_rect());
    end
  endtask

  task automatic test_no_idle();
    pcrm_pkg::cfg_t c;
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    c = random_layout();
    c.chain_mode[0] = 1'b1;
    apply_layout(c);
    repeat (30) send_rect(random_rect());
    settle();
    send_idle_pct = 29;
    recv_idle_pct = 29;
  endtask

  task automatic test_backpressure();
    apply_layout(make_layout(32, 256, 16, 16, 512, 0, 3));
    send_idle_pct = 0;
    hold_left = 300;
    repeat (24) send_rect(random_rect());
    send_idle_pct = 29;
  endtask

  initial begin
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_rect.valid  <= 1'b0;
    in_rect.rect_x <= '0;
    in_rect.rect_y <= '0;
    in_rect.rect_w <= '0;
    in_rect.rect_h <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_layout();
    test_chain_modes();
    test_special_layouts();
    test_random_traffic();
    test_no_idle();
    test_backpressure();
    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pcrm_pkg.sv
rtl/core/pcrm_rect_if.sv
rtl/core/pcrm_piece_if.sv
rtl/core/pcrm_cfg_regs.sv
rtl/core/pcrm_divider.sv
rtl/core/pcrm_datapath.sv
rtl/core/pcrm_ctrl.sv
rtl/core/panel_chain_rect_mapper_unit.sv
bench/testbench.sv
